[hdl/hbbc_pkg.sv]
`default_nettype none
package hbbc_pkg;

  typedef enum logic [1:0] {
    OP_GET     = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PIN     = 2'd2,
    OP_UNPIN   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FREE  = 2'd1,
    ST_ZERO_CNT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_SCAN,
    S_POOL,
    S_WRITE,
    S_SIMPLE,
    S_OUT
  } state_t;

  localparam int unsigned CNT_W   = 8;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};
  localparam int unsigned BKT_W   = 6;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] device;
    logic [31:0] block_number;
    logic [4:0]  entry_index;
    logic [31:0] current_tick;
  } req_t;

  typedef struct packed {
    logic [4:0] chosen_entry;
    logic       hit;
    logic       need_read;
    logic [1:0] status;
  } rsp_t;

  // Entry record: device, block, bucket, count, stamp, valid, linked, order.
  localparam int unsigned REC_W = 32 + 32 + BKT_W + CNT_W + 32 + 1 + 1 + 32;

  typedef struct packed {
    logic [31:0]      tag_device;
    logic [31:0]      tag_block;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] ref_count;
    logic [31:0]      free_stamp;
    logic             contents_valid;
    logic             in_bucket;
    logic [31:0]      link_order;
  } rec_t;

endpackage
`default_nettype wire

[hdl/hbbc_if.sv]
`default_nettype none
interface hbbc_req_if;
  logic          valid;
  logic          ready;
  hbbc_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface hbbc_rsp_if;
  logic          valid;
  logic          ready;
  hbbc_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hdl/hashed_block_buffer_cache.sv]
`default_nettype none
// Channel | Dir | Interface          | Payload
// in_     | in  | hbbc_req_if.sink   | operation, device, block_number, entry_index,
//         |     |                    | current_tick
// out_    | out | hbbc_rsp_if.source | chosen_entry, hit, need_read, status
//
// Get: reduce the block number to its bucket, scan the bucket through the
// record RAM read port, scan the pool when the bucket holds neither a match
// nor a free entry, write back unless the pool has none free, then the result.
// Release, pin, unpin: read, write (when the index and count allow), result.
// Reset clears all records; no transaction meanwhile.
// One transaction at a time; a stalled result holds the block.
module hashed_block_buffer_cache #(
  parameter int unsigned ENTRY_COUNT  = 32,
  parameter int unsigned BUCKET_COUNT = 13
) (
  input wire logic clk,
  input wire logic rst_n,
  hbbc_req_if.sink   in_ch,
  hbbc_rsp_if.source out_ch
);
  localparam int unsigned AW = $clog2(ENTRY_COUNT);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned HS = $clog2(BUCKET_COUNT);
  localparam logic [63:0] RECIP = (64'd1 << (32 + HS)) / BUCKET_COUNT;
  localparam logic [15:0] RLO   = RECIP[15:0];
  localparam logic [16:0] RHI   = RECIP[32:16];
  localparam logic [31:0] BC32  = 32'(BUCKET_COUNT);
  localparam logic [7:0]  BC8   = 8'(BUCKET_COUNT);

  hbbc_pkg::state_t state_r, state_nxt;
  hbbc_pkg::req_t   req_r;
  hbbc_pkg::rsp_t   rsp_r, rsp_nxt;
  logic [CW-1:0]    ptr_r, ptr_nxt;
  logic             clr_r;
  logic [31:0]      lseq_r;

  logic             hit_f_r, lru_f_r;
  logic [AW-1:0]    hit_e_r, lru_e_r;
  logic [31:0]      hit_age_r, lru_age_r, lru_stamp_r;
  hbbc_pkg::rec_t   hit_rec_r, lru_rec_r;
  logic [hbbc_pkg::BKT_W-1:0] bkt_r;

  logic [1:0]       hcnt_r;
  logic [47:0]      p_lo_r;
  logic [48:0]      p_hi_r;
  logic [31:0]      q_r;
  logic [7:0]       rem_r;

  logic             we;
  logic [AW-1:0]    waddr, raddr;
  hbbc_pkg::rec_t   wrec, rrec;
  logic [AW-1:0]    rd_e_r;
  logic             rd_v_r;

  hbbc_ram #(.WIDTH(hbbc_pkg::REC_W), .DEPTH(ENTRY_COUNT)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wrec),
    .raddr (raddr),
    .rdata (rrec)
  );

  assign in_ch.ready    = (state_r == hbbc_pkg::S_IDLE) && !clr_r;
  assign out_ch.valid   = (state_r == hbbc_pkg::S_OUT);
  assign out_ch.payload = rsp_r;

  wire logic          accept   = in_ch.valid && in_ch.ready;
  wire logic [31:0]   age      = lseq_r - rrec.link_order;
  wire logic          in_pool  = {{(32-CW){1'b0}}, ptr_r} < ENTRY_COUNT;
  wire logic          idx_ok   = {27'd0, req_r.entry_index} < ENTRY_COUNT;
  wire logic [AW-1:0] idx      = AW'(req_r.entry_index);
  wire logic [64:0]   hash_sum = {17'd0, p_lo_r} + {p_hi_r, 16'd0};
  wire logic [31:0]   hash_dif = req_r.block_number - q_r * BC32;
  wire logic [7:0]    hash_bkt = (rem_r >= BC8) ? rem_r - BC8 : rem_r;

  always_comb begin
    raddr = ptr_r[AW-1:0];
    if (state_r == hbbc_pkg::S_IDLE) raddr = AW'(in_ch.payload.entry_index);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      hbbc_pkg::S_IDLE:
        if (accept) begin
          state_nxt = (in_ch.payload.operation == hbbc_pkg::OP_GET) ?
                      hbbc_pkg::S_HASH : hbbc_pkg::S_SIMPLE;
        end
      hbbc_pkg::S_HASH:
        if (hcnt_r == 2'd3) state_nxt = hbbc_pkg::S_SCAN;
      hbbc_pkg::S_SCAN:
        if (!in_pool && rd_v_r == 1'b0 && ptr_r != '0) begin
          state_nxt = (hit_f_r || lru_f_r) ? hbbc_pkg::S_WRITE : hbbc_pkg::S_POOL;
        end
      hbbc_pkg::S_POOL:
        if (rd_v_r && rrec.ref_count == '0) state_nxt = hbbc_pkg::S_WRITE;
        else if (!in_pool && !rd_v_r) state_nxt = hbbc_pkg::S_OUT;
      hbbc_pkg::S_WRITE:  state_nxt = hbbc_pkg::S_OUT;
      hbbc_pkg::S_SIMPLE: state_nxt = hbbc_pkg::S_OUT;
      hbbc_pkg::S_OUT:    if (out_ch.ready) state_nxt = hbbc_pkg::S_IDLE;
      default:            state_nxt = hbbc_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ptr_nxt = ptr_r;
    we      = 1'b0;
    waddr   = idx;
    wrec    = rrec;
    rsp_nxt = rsp_r;
    unique case (state_r)
      hbbc_pkg::S_IDLE: ptr_nxt = '0;
      hbbc_pkg::S_SCAN, hbbc_pkg::S_POOL:
        if (in_pool) ptr_nxt = ptr_r + 1'b1;
      hbbc_pkg::S_WRITE:
        if (hit_f_r) begin
          we   = 1'b1;
          waddr = hit_e_r;
          wrec = hit_rec_r;
          if (hit_rec_r.ref_count != hbbc_pkg::CNT_MAX) wrec.ref_count = hit_rec_r.ref_count + 1'b1;
          wrec.contents_valid = 1'b1;
          rsp_nxt = '{chosen_entry: 5'(hit_e_r), hit: 1'b1,
                      need_read: !hit_rec_r.contents_valid, status: hbbc_pkg::ST_OK};
        end else begin
          we   = 1'b1;
          waddr = lru_e_r;
          wrec = lru_rec_r;
          if (!lru_f_r) begin
            wrec.in_bucket  = 1'b1;
            wrec.link_order = lseq_r + 32'd1;
          end
          wrec.tag_device     = req_r.device;
          wrec.tag_block      = req_r.block_number;
          wrec.bucket         = bkt_r;
          wrec.ref_count      = hbbc_pkg::CNT_W'(1);
          wrec.contents_valid = 1'b1;
          rsp_nxt = '{chosen_entry: 5'(lru_e_r), hit: 1'b0, need_read: 1'b1,
                      status: hbbc_pkg::ST_OK};
        end
      hbbc_pkg::S_SIMPLE: begin
        rsp_nxt = '{chosen_entry: req_r.entry_index, hit: 1'b0, need_read: 1'b0,
                    status: hbbc_pkg::ST_OK};
        if (idx_ok) begin
          if (req_r.operation == hbbc_pkg::OP_PIN) begin
            we = 1'b1;
            if (rrec.ref_count != hbbc_pkg::CNT_MAX) wrec.ref_count = rrec.ref_count + 1'b1;
          end else if (rrec.ref_count == '0) begin
            rsp_nxt.status = hbbc_pkg::ST_ZERO_CNT;
          end else begin
            we = 1'b1;
            wrec.ref_count = rrec.ref_count - 1'b1;
            if (req_r.operation == hbbc_pkg::OP_RELEASE && rrec.ref_count == hbbc_pkg::CNT_W'(1))
              wrec.free_stamp = req_r.current_tick;
          end
        end
      end
      default: ;
    endcase
    if (state_r == hbbc_pkg::S_SCAN && state_nxt != hbbc_pkg::S_SCAN) begin
      ptr_nxt = '0;
    end
    if (state_r == hbbc_pkg::S_POOL && state_nxt == hbbc_pkg::S_OUT) begin
      rsp_nxt = '{chosen_entry: 5'd0, hit: 1'b0, need_read: 1'b0, status: hbbc_pkg::ST_NO_FREE};
    end
    if (clr_r) begin
      we    = 1'b1;
      waddr = ptr_r[AW-1:0];
      wrec  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hbbc_pkg::S_IDLE;
      clr_r   <= 1'b1;
      ptr_r   <= '0;
      lseq_r  <= '0;
      rd_v_r  <= 1'b0;
      hit_f_r <= 1'b0;
      lru_f_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clr_r) begin
        if (ptr_r == CW'(ENTRY_COUNT - 1)) begin
          clr_r <= 1'b0;
          ptr_r <= '0;
        end else begin
          ptr_r <= ptr_r + 1'b1;
        end
      end else begin
        ptr_r <= ptr_nxt;
      end
      rd_v_r <= (state_r == hbbc_pkg::S_SCAN || state_r == hbbc_pkg::S_POOL) && in_pool;
      if (accept) begin
        hit_f_r <= 1'b0;
        lru_f_r <= 1'b0;
      end
      if (state_r == hbbc_pkg::S_SCAN && rd_v_r && rrec.in_bucket &&
          rrec.bucket == bkt_r) begin
        if (rrec.tag_device == req_r.device && rrec.tag_block == req_r.block_number) begin
          if (!hit_f_r || age < hit_age_r) begin
            hit_f_r <= 1'b1;
            hit_e_r <= rd_e_r;
            hit_age_r <= age;
            hit_rec_r <= rrec;
          end
        end else if (rrec.ref_count == '0) begin
          if (!lru_f_r || rrec.free_stamp < lru_stamp_r ||
              (rrec.free_stamp == lru_stamp_r && age < lru_age_r)) begin
            lru_f_r <= 1'b1;
            lru_e_r <= rd_e_r;
            lru_age_r <= age;
            lru_stamp_r <= rrec.free_stamp;
            lru_rec_r <= rrec;
          end
        end
      end
      if (state_r == hbbc_pkg::S_POOL && rd_v_r && rrec.ref_count == '0) begin
        lru_e_r   <= rd_e_r;
        lru_rec_r <= rrec;
      end
      if (state_r == hbbc_pkg::S_WRITE && !hit_f_r && !lru_f_r) lseq_r <= lseq_r + 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    rd_e_r <= raddr;
    rsp_r  <= rsp_nxt;
    if (accept) begin
      req_r  <= in_ch.payload;
      hcnt_r <= '0;
    end else if (state_r == hbbc_pkg::S_HASH) begin
      hcnt_r <= hcnt_r + 2'd1;
    end
    if (state_r == hbbc_pkg::S_HASH) begin
      p_lo_r <= 48'(req_r.block_number) * 48'(RLO);
      p_hi_r <= 49'(req_r.block_number) * 49'(RHI);
      q_r    <= 32'(hash_sum >> (32 + HS));
      rem_r  <= hash_dif[7:0];
      bkt_r  <= hash_bkt[hbbc_pkg::BKT_W-1:0];
    end
  end
endmodule
`default_nettype wire

[hdl/hbbc_ram.sv]
`default_nettype none
module hbbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
